@@ hw/rtl/c3f_pkg.sv @@
// shared types, widths and register codes for the 3x3 line buffer filter
`timescale 1ns / 1ps

package c3f_pkg;

  // payload widths
  localparam int PIX_W     = 8;
  localparam int COL_W     = 10;
  localparam int ROW_W     = 12;
  localparam int COEF_W    = 16;
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 2;
  localparam int LW_W      = 11;

  // arithmetic widths: 9-bit signed pixel times 16-bit coefficient
  localparam int PROD_W   = 25;
  localparam int ROWSUM_W = 27;
  localparam int SUM_W    = 29;
  localparam int FRAC_W   = 15;

  // queue between front and back
  localparam int QDEPTH  = 4;
  localparam int Q_PTR_W = $clog2(QDEPTH);
  localparam int Q_CNT_W = $clog2(QDEPTH + 1);

  // reset values
  localparam logic [CFG_W-1:0] COEF_TOP_RESET = '0;
  localparam logic [CFG_W-1:0] COEF_MID_RESET = 48'h0000_7FFF_0000;
  localparam logic [CFG_W-1:0] COEF_BOT_RESET = '0;
  localparam logic [LW_W-1:0]  LW_RESET       = 11'd1024;
  localparam logic [LW_W-1:0]  LW_MIN         = 11'd3;
  localparam logic [ROW_W-1:0] ROW_MAX        = 12'hFFF;
  localparam logic [SUM_W-1:0] ROUND_HALF     = 29'd16384;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_TOP   = 2'd0,
    REG_COEF_MID   = 2'd1,
    REG_COEF_BOT   = 2'd2,
    REG_LINE_WIDTH = 2'd3
  } cfg_reg_t;

  // 3x3 window, entry 3*row+col, row 0 is the oldest line
  typedef logic [8:0][PIX_W-1:0] window_t;

  // coefficient rows, column 0 in bits 15:0
  typedef logic [2:0][CFG_W-1:0] coef_set_t;

  // one job handed from front to back
  typedef struct packed {
    window_t          window;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
    logic             last;
  } job_t;

endpackage

@@ hw/rtl/c3f_stream_if.sv @@
// stream interfaces for pixel requests and filter results
`timescale 1ns / 1ps

interface c3f_pixel_if;
  logic                      valid;
  logic                      ready;
  logic [c3f_pkg::PIX_W-1:0] pixel_in;
  logic                      frame_start;

  modport source (output valid, pixel_in, frame_start, input ready);
  modport sink   (input valid, pixel_in, frame_start, output ready);
endinterface

interface c3f_result_if;
  logic                      valid;
  logic                      ready;
  logic [c3f_pkg::PIX_W-1:0] filtered_pixel;
  logic [c3f_pkg::COL_W-1:0] out_column;
  logic [c3f_pkg::ROW_W-1:0] out_row;
  logic                      row_last;

  modport source (output valid, filtered_pixel, out_column, out_row, row_last, input ready);
  modport sink   (input valid, filtered_pixel, out_column, out_row, row_last, output ready);
endinterface

@@ hw/rtl/c3f_front.sv @@
// front end: raster counters, two line stores and the 3x3 window
`timescale 1ns / 1ps

module c3f_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  c3f_pixel_if.sink                   pixel_stream,
  input  logic [c3f_pkg::LW_W-1:0]    line_width,
  input  logic [c3f_pkg::Q_CNT_W-1:0] q_count,
  output logic                        push_valid,
  output c3f_pkg::job_t               push_job
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);

  logic [XW-1:0]                column_count, column_count_next;
  logic [c3f_pkg::ROW_W-1:0]    row_count, row_count_next;
  logic [WW-1:0]                eff_width;
  logic [XW-1:0]                col_base, x;
  logic [c3f_pkg::ROW_W-1:0]    y;
  logic                         last, emit, accept;
  logic [c3f_pkg::Q_CNT_W-1:0]  q_used;

  // stage 1 registers
  logic                         s1_valid;
  logic [XW-1:0]                s1_x;
  logic [c3f_pkg::PIX_W-1:0]    s1_pix;
  logic [c3f_pkg::ROW_W-1:0]    s1_row;
  logic                         s1_last;
  logic                         s1_emit;

  // line stores and their registered read data
  logic [c3f_pkg::PIX_W-1:0]    store_upper [MAX_WIDTH];
  logic [c3f_pkg::PIX_W-1:0]    store_lower [MAX_WIDTH];
  logic [c3f_pkg::PIX_W-1:0]    rd_upper, rd_lower;
  logic                         bypass;

  c3f_pkg::window_t             window, window_next;

  // accept only with room reserved in the queue for this request
  assign q_used             = q_count + c3f_pkg::Q_CNT_W'(s1_valid);
  assign pixel_stream.ready = (q_used < c3f_pkg::Q_CNT_W'(c3f_pkg::QDEPTH));
  assign accept             = pixel_stream.valid && pixel_stream.ready;

  // clamp the configured width to 3..MAX_WIDTH
  always_comb begin
    if (line_width < c3f_pkg::LW_MIN) begin
      eff_width = WW'(3);
    end else if (32'(line_width) > MAX_WIDTH) begin
      eff_width = WW'(MAX_WIDTH);
    end else begin
      eff_width = WW'(line_width);
    end
  end

  // position of the incoming pixel
  always_comb begin
    col_base = pixel_stream.frame_start ? '0 : column_count;
    y        = pixel_stream.frame_start ? '0 : row_count;
    if (WW'(col_base) >= eff_width) begin
      x = XW'(eff_width - WW'(1));
    end else begin
      x = col_base;
    end
    last = ((WW'(x) + WW'(1)) >= eff_width);
    emit = (x >= XW'(2)) && (y >= c3f_pkg::ROW_W'(2));
  end

  // next counter values
  always_comb begin
    if (last) begin
      column_count_next = '0;
      row_count_next    = (y == c3f_pkg::ROW_MAX) ? y : y + c3f_pkg::ROW_W'(1);
    end else begin
      column_count_next = x + XW'(1);
      row_count_next    = y;
    end
  end

  // counters and stage 1 control
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      s1_valid     <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        column_count <= column_count_next;
        row_count    <= row_count_next;
      end
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x    <= x;
      s1_pix  <= pixel_stream.pixel_in;
      s1_row  <= y;
      s1_last <= last;
      s1_emit <= emit;
    end
  end

  // line store read, with bypass of the write landing on the same edge
  assign bypass = s1_valid && (s1_x == x);

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_upper <= bypass ? rd_lower : store_upper[x];
      rd_lower <= bypass ? s1_pix   : store_lower[x];
    end
  end

  // line store write: rows move up by one
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      store_upper[s1_x] <= rd_lower;
      store_lower[s1_x] <= s1_pix;
    end
  end

  // window shift
  always_comb begin
    window_next    = window;
    window_next[0] = window[1];
    window_next[1] = window[2];
    window_next[2] = rd_upper;
    window_next[3] = window[4];
    window_next[4] = window[5];
    window_next[5] = rd_lower;
    window_next[6] = window[7];
    window_next[7] = window[8];
    window_next[8] = s1_pix;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (s1_valid) begin
      window <= window_next;
    end
  end

  // job for the back end
  assign push_valid      = s1_valid && s1_emit;
  assign push_job.window = window_next;
  assign push_job.column = c3f_pkg::COL_W'(s1_x - XW'(2));
  assign push_job.row    = s1_row - c3f_pkg::ROW_W'(2);
  assign push_job.last   = s1_last;

endmodule

@@ hw/rtl/c3f_queue.sv @@
// short job queue between front and back
`timescale 1ns / 1ps

module c3f_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push_valid,
  input  c3f_pkg::job_t               push_job,
  input  logic                        pop,
  output logic                        pop_valid,
  output c3f_pkg::job_t               pop_job,
  output logic [c3f_pkg::Q_CNT_W-1:0] count
);

  c3f_pkg::job_t                entries [c3f_pkg::QDEPTH];
  logic [c3f_pkg::Q_PTR_W-1:0]  wr_ptr, rd_ptr;
  logic                         do_pop;

  assign pop_valid = (count != '0);
  assign pop_job   = entries[rd_ptr];
  assign do_pop    = pop && pop_valid;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_valid) begin
        wr_ptr <= wr_ptr + c3f_pkg::Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + c3f_pkg::Q_PTR_W'(1);
      end
      count <= count + c3f_pkg::Q_CNT_W'(push_valid) - c3f_pkg::Q_CNT_W'(do_pop);
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push_valid) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

@@ hw/rtl/c3f_back.sv @@
// back end: products, row sums, rounding and saturation, output register
`timescale 1ns / 1ps

module c3f_back (
  input  logic               clk,
  input  logic               rst,
  input  c3f_pkg::coef_set_t coef,
  input  logic               job_valid,
  input  c3f_pkg::job_t      job,
  output logic               pop,
  c3f_result_if.source       result_stream
);

  logic en1, en2, en3;

  // stage b1: nine products
  logic                                    v1;
  logic signed [c3f_pkg::PROD_W-1:0]       prod [9];
  logic signed [c3f_pkg::PROD_W-1:0]       prod_next [9];
  logic [c3f_pkg::COL_W-1:0]               col1;
  logic [c3f_pkg::ROW_W-1:0]               row1;
  logic                                    last1;

  // stage b2: three row sums
  logic                                    v2;
  logic signed [c3f_pkg::ROWSUM_W-1:0]     rsum [3];
  logic signed [c3f_pkg::ROWSUM_W-1:0]     rsum_next [3];
  logic [c3f_pkg::COL_W-1:0]               col2;
  logic [c3f_pkg::ROW_W-1:0]               row2;
  logic                                    last2;

  // stage b3: output register
  logic                                    v3;
  logic signed [c3f_pkg::SUM_W-1:0]        total;
  logic [c3f_pkg::PIX_W-1:0]               pix_next;
  logic [c3f_pkg::PIX_W-1:0]               pix3;
  logic [c3f_pkg::COL_W-1:0]               col3;
  logic [c3f_pkg::ROW_W-1:0]               row3;
  logic                                    last3;

  // stall chain
  assign en3 = !v3 || result_stream.ready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign pop = job_valid && en1;

  // pixel times signed coefficient, both operands at full product width
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_next[3*r+c] =
          $signed({{(c3f_pkg::PROD_W-c3f_pkg::PIX_W){1'b0}}, job.window[3*r+c]}) *
          $signed({{(c3f_pkg::PROD_W-c3f_pkg::COEF_W){
                      coef[r][c3f_pkg::COEF_W*c+c3f_pkg::COEF_W-1]}},
                   coef[r][c3f_pkg::COEF_W*c +: c3f_pkg::COEF_W]});
      end
    end
  end

  // sum each window row
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      rsum_next[r] = c3f_pkg::ROWSUM_W'(prod[3*r]) +
                     c3f_pkg::ROWSUM_W'(prod[3*r+1]) +
                     c3f_pkg::ROWSUM_W'(prod[3*r+2]);
    end
  end

  // total, round half up, clamp to 0..255
  always_comb begin
    total = c3f_pkg::SUM_W'(rsum[0]) + c3f_pkg::SUM_W'(rsum[1]) +
            c3f_pkg::SUM_W'(rsum[2]) + $signed(c3f_pkg::ROUND_HALF);
    if (total[c3f_pkg::SUM_W-1]) begin
      pix_next = '0;
    end else if (|total[c3f_pkg::SUM_W-2:c3f_pkg::FRAC_W+c3f_pkg::PIX_W]) begin
      pix_next = '1;
    end else begin
      pix_next = total[c3f_pkg::FRAC_W +: c3f_pkg::PIX_W];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= job_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (en1) begin
      prod  <= prod_next;
      col1  <= job.column;
      row1  <= job.row;
      last1 <= job.last;
    end
    if (en2) begin
      rsum  <= rsum_next;
      col2  <= col1;
      row2  <= row1;
      last2 <= last1;
    end
    if (en3) begin
      pix3  <= pix_next;
      col3  <= col2;
      row3  <= row2;
      last3 <= last2;
    end
  end

  assign result_stream.valid          = v3;
  assign result_stream.filtered_pixel = pix3;
  assign result_stream.out_column     = col3;
  assign result_stream.out_row        = row3;
  assign result_stream.row_last       = last3;

endmodule

@@ hw/rtl/conv3x3_line_buffer_filter_top.sv @@
// top level of the 3x3 line buffer filter: config registers and block wiring
//
//  channel        dir  handshake     payload
//  pixel_stream   in   valid/ready   pixel_in[7:0], frame_start
//  result_stream  out  valid/ready   filtered_pixel[7:0], out_column[9:0],
//                                    out_row[11:0], row_last
//  cfg            in   cfg_we        cfg_index[1:0], cfg_data[47:0]
//
// one pixel per clock sustained while the job queue has room; a taken pixel passes
// through line store read, window update, queue, multiply, sum and output.
// the line stores are single-write memories read once per pixel with a
// same-address bypass; the window and products advance one pixel a cycle unless stalled.
// reset is synchronous; line store contents are not cleared by it.
// the front stalls only when the four-entry job queue has no free slot;
// output backpressure fills the back pipeline and then the queue.
`timescale 1ns / 1ps

module conv3x3_line_buffer_filter_top #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  c3f_pixel_if.sink                     pixel_stream,
  c3f_result_if.source                  result_stream,
  input  logic                          cfg_we,
  input  logic [c3f_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [c3f_pkg::CFG_W-1:0]     cfg_data
);

  c3f_pkg::coef_set_t            coef;
  logic [c3f_pkg::LW_W-1:0]      line_width;
  logic                          push_valid;
  c3f_pkg::job_t                 push_job;
  logic                          pop, pop_valid;
  c3f_pkg::job_t                 pop_job;
  logic [c3f_pkg::Q_CNT_W-1:0]   q_count;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coef[0]    <= c3f_pkg::COEF_TOP_RESET;
      coef[1]    <= c3f_pkg::COEF_MID_RESET;
      coef[2]    <= c3f_pkg::COEF_BOT_RESET;
      line_width <= c3f_pkg::LW_RESET;
    end else if (cfg_we) begin
      unique case (c3f_pkg::cfg_reg_t'(cfg_index))
        c3f_pkg::REG_COEF_TOP:   coef[0]    <= cfg_data;
        c3f_pkg::REG_COEF_MID:   coef[1]    <= cfg_data;
        c3f_pkg::REG_COEF_BOT:   coef[2]    <= cfg_data;
        c3f_pkg::REG_LINE_WIDTH: line_width <= cfg_data[c3f_pkg::LW_W-1:0];
        default: ;
      endcase
    end
  end

  // front: counters, line stores, window
  c3f_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .pixel_stream (pixel_stream),
    .line_width   (line_width),
    .q_count      (q_count),
    .push_valid   (push_valid),
    .push_job     (push_job)
  );

  // job queue
  c3f_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_job   (push_job),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_job    (pop_job),
    .count      (q_count)
  );

  // back: arithmetic and output register
  c3f_back u_back (
    .clk           (clk),
    .rst           (rst),
    .coef          (coef),
    .job_valid     (pop_valid),
    .job           (pop_job),
    .pop           (pop),
    .result_stream (result_stream)
  );

endmodule

@@ hw/rtl/c3f_checker.sv @@
// port-level checks for the 3x3 line buffer filter, bound to the top level
`timescale 1ns / 1ps

module c3f_checker #(
  parameter int MAX_WIDTH = 1024
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          res_valid,
  input logic                          res_ready,
  input logic [c3f_pkg::PIX_W-1:0]     res_pixel,
  input logic [c3f_pkg::COL_W-1:0]     res_column,
  input logic [c3f_pkg::ROW_W-1:0]     res_row,
  input logic                          res_last,
  input logic                          cfg_we,
  input logic [c3f_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [c3f_pkg::CFG_W-1:0]     cfg_data
);

  logic [c3f_pkg::LW_W-1:0] lw;
  logic [12:0]              effw;
  logic                     effw_ok;
  logic [12:0]              col_plus;

  // shadow of the line width register
  always_ff @(posedge clk) begin
    if (rst) begin
      lw <= c3f_pkg::LW_RESET;
    end else if (cfg_we &&
                 (c3f_pkg::cfg_reg_t'(cfg_index) == c3f_pkg::REG_LINE_WIDTH)) begin
      lw <= cfg_data[c3f_pkg::LW_W-1:0];
    end
  end

  // clamped width as the datapath sees it
  always_comb begin
    if (lw < c3f_pkg::LW_MIN) begin
      effw = 13'd3;
    end else if (32'(lw) > MAX_WIDTH) begin
      effw = 13'(MAX_WIDTH);
    end else begin
      effw = 13'(lw);
    end
  end

  assign effw_ok  = (effw < 13'd1027);
  assign col_plus = {3'b000, res_column} + 13'd3;

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid &&
      $stable({res_pixel, res_column, res_row, res_last}))
    else $error("stalled result changed");

  // the last output of a row sits at column width-3
  a_last_col: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_last && effw_ok |-> col_plus == effw)
    else $error("row_last at wrong column");

  // any other output lies left of it
  a_inner_col: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_last && effw_ok |-> col_plus < effw)
    else $error("non-last output at or beyond row end");

endmodule

bind conv3x3_line_buffer_filter_top c3f_checker #(
  .MAX_WIDTH (MAX_WIDTH)
) u_checker (
  .clk        (clk),
  .rst        (rst),
  .res_valid  (result_stream.valid),
  .res_ready  (result_stream.ready),
  .res_pixel  (result_stream.filtered_pixel),
  .res_column (result_stream.out_column),
  .res_row    (result_stream.out_row),
  .res_last   (result_stream.row_last),
  .cfg_we     (cfg_we),
  .cfg_index  (cfg_index),
  .cfg_data   (cfg_data)
);
